>>> sv/assert_macros.svh
// assertion helpers, clocked on clk and disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge
`define UEP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// when ante holds, cons holds in the next cycle
`define UEP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/uart_ep_pkg.sv
package uart_ep_pkg;

	localparam int DATA_BITS_DEF = 8;
	localparam int BYTE_W        = 8;
	localparam int RATIO_W       = 5;
	localparam int TICK_W        = 4;
	localparam int BSTATE_W      = 4;

	localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(4);
	localparam logic [RATIO_W-1:0] RATIO_MIN   = RATIO_W'(1);
	localparam logic [RATIO_W-1:0] RATIO_MAX   = RATIO_W'(16);

	typedef logic [RATIO_W-1:0]  ratio_t;
	typedef logic [BSTATE_W-1:0] bstate_t;

	typedef struct packed {
		logic              cmd;
		logic [BYTE_W-1:0] tx_byte;
		logic              rx_level;
	} in_word_t;

	typedef struct packed {
		logic              tx_level;
		logic              tx_done;
		logic              busy_res;
		logic              rx_valid;
		logic [BYTE_W-1:0] rx_byte;
		logic              parity_error;
	} out_word_t;

	// command codes on the input word
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

endpackage

>>> sv/uart_ep_chan.sv
interface uart_ep_chan #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> sv/uart_ep_core.sv
module uart_ep_core import uart_ep_pkg::*; #(
	parameter int DATA_BITS = DATA_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  in_word_t  word,
	input  ratio_t    ratio,
	output out_word_t res
);

	typedef enum logic [1:0] {MODE_IDLE, MODE_RX, MODE_TX} mode_t;

	localparam bstate_t ST_START  = '0;
	localparam bstate_t ST_LAST   = BSTATE_W'(DATA_BITS);
	localparam bstate_t ST_PARITY = BSTATE_W'(DATA_BITS + 1);
	localparam bstate_t ST_STOP   = BSTATE_W'(DATA_BITS + 2);
	localparam bstate_t ST_END    = BSTATE_W'(DATA_BITS + 4);

	mode_t                mode_q, mode_d;
	bstate_t              tx_st_q, tx_st_d;
	logic [DATA_BITS-1:0] tx_shift_q, tx_shift_d;
	logic [TICK_W-1:0]    tick_q, tick_d, tick_step;
	bstate_t              rx_st_q, rx_st_d, rx_st_n;
	logic [DATA_BITS-1:0] rx_data_q, rx_data_d;
	logic                 rx_bad_q, rx_bad_d;
	logic                 line_q, line_d;
	ratio_t               r_eff;
	logic [RATIO_W-1:0]   tick_inc;
	logic                 per_end;

	// clamp ratio into 1..16
	always_comb begin
		if (ratio < RATIO_MIN) begin
			r_eff = RATIO_MIN;
		end else if (ratio > RATIO_MAX) begin
			r_eff = RATIO_MAX;
		end else begin
			r_eff = ratio;
		end
	end

	assign tick_inc  = {1'b0, tick_q} + RATIO_W'(1);
	assign per_end   = (tick_inc >= r_eff);
	assign tick_step = per_end ? '0 : tick_inc[TICK_W-1:0];
	assign rx_st_n   = per_end ? rx_st_q + BSTATE_W'(1) : rx_st_q;

	always_comb begin
		mode_d     = mode_q;
		tx_st_d    = tx_st_q;
		tx_shift_d = tx_shift_q;
		tick_d     = tick_q;
		rx_st_d    = rx_st_q;
		rx_data_d  = rx_data_q;
		rx_bad_d   = rx_bad_q;
		line_d     = line_q;
		res        = '0;
		case (mode_q)
			MODE_TX: begin
				if (word.cmd == CMD_TICK) begin
					tick_d = tick_step;
					if (per_end) begin
						if (tx_st_q == ST_START) begin
							line_d = 1'b0;
						end else if (tx_st_q <= ST_LAST) begin
							for (int i = 0; i < DATA_BITS; i++) begin
								if (tx_st_q == BSTATE_W'(i + 1)) line_d = tx_shift_q[i];
							end
						end else if (tx_st_q == ST_PARITY) begin
							line_d = ^tx_shift_q;
						end else if (tx_st_q == ST_STOP) begin
							line_d = 1'b1;
						end
						// stop delay keeps the line as is
						tx_st_d = tx_st_q + BSTATE_W'(1);
						if (tx_st_d >= ST_END) begin
							res.tx_done = 1'b1;
							mode_d      = MODE_IDLE;
						end
					end
				end
			end
			MODE_RX: begin
				if (word.cmd == CMD_TICK) begin
					tick_d  = tick_step;
					rx_st_d = rx_st_n;
					if (rx_st_n >= ST_STOP) begin
						rx_st_d      = ST_STOP;
						res.rx_valid = 1'b1;
						res.rx_byte[DATA_BITS-1:0] = rx_data_q;
						res.parity_error = rx_bad_q;
						mode_d       = MODE_IDLE;
					end else if (rx_st_n == ST_PARITY) begin
						if (word.rx_level != ^rx_data_q) rx_bad_d = 1'b1;
					end else if (rx_st_n != ST_START) begin
						// any high sample sets the bit
						for (int i = 0; i < DATA_BITS; i++) begin
							if (rx_st_n == BSTATE_W'(i + 1) && word.rx_level) rx_data_d[i] = 1'b1;
						end
					end
				end
			end
			default: begin
				if (word.cmd == CMD_LOAD) begin
					tx_shift_d = word.tx_byte[DATA_BITS-1:0];
					tx_st_d    = ST_START;
					tick_d     = '0;
					mode_d     = MODE_TX;
				end else if (!word.rx_level) begin
					tick_d    = '0;
					rx_st_d   = ST_START;
					rx_data_d = '0;
					rx_bad_d  = 1'b0;
					mode_d    = MODE_RX;
				end
			end
		endcase
		res.tx_level = line_d;
		res.busy_res = (mode_d != MODE_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			tx_st_q    <= ST_START;
			tx_shift_q <= '0;
			tick_q     <= '0;
			rx_st_q    <= ST_STOP;
			rx_data_q  <= '0;
			rx_bad_q   <= 1'b0;
			line_q     <= 1'b1;
		end else if (step) begin
			mode_q     <= mode_d;
			tx_st_q    <= tx_st_d;
			tx_shift_q <= tx_shift_d;
			tick_q     <= tick_d;
			rx_st_q    <= rx_st_d;
			rx_data_q  <= rx_data_d;
			rx_bad_q   <= rx_bad_d;
			line_q     <= line_d;
		end
	end

endmodule

>>> sv/uart_even_parity_txrx.sv
// channel  dir  payload                                             handshake
// din      in   cmd, tx_byte, rx_level                              valid/ready
// dout     out  tx_level, tx_done, busy_res, rx_valid, rx_byte,     valid/ready
//               parity_error
// cfg      in   oversample_ratio (5 bits)                           valid/ready
//
// one word per cycle while dout is not stalled; each input word is held in the input
// register, then its result in the result register after the state update
// arst_n clears the uart state, the ratio (back to 4) and both valid flags
// a stalled dout holds the result register; din keeps flowing until the
// input register is also full, cfg is always ready
`include "assert_macros.svh"

module uart_even_parity_txrx import uart_ep_pkg::*; #(
	parameter int DATA_BITS = DATA_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	uart_ep_chan.sink   din,
	uart_ep_chan.source dout,
	uart_ep_chan.sink   cfg
);

	ratio_t    ratio_q;
	logic      valid_s1;
	in_word_t  word_s1;
	logic      valid_s2;
	out_word_t res_s2;
	out_word_t res;
	logic      advance;

	assign cfg.ready  = 1'b1;
	assign advance    = valid_s1 && (!valid_s2 || dout.ready);
	assign din.ready  = !valid_s1 || advance;
	assign dout.valid = valid_s2;
	assign dout.data  = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q <= RATIO_RESET;
		end else if (cfg.valid) begin
			ratio_q <= ratio_t'(cfg.data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (din.ready) valid_s1 <= din.valid;
			if (!valid_s2 || dout.ready) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (din.valid && din.ready) word_s1 <= din.data;
		if (advance) res_s2 <= res;
	end

	uart_ep_core #(.DATA_BITS(DATA_BITS)) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.word   (word_s1),
		.ratio  (ratio_q),
		.res    (res)
	);

	// a reported byte always ends the receive
	`UEP_ASSERT(a_rx_ends, !(valid_s2 && res_s2.rx_valid && res_s2.busy_res), "rx word while busy")
	// the frame ends with the line high
	`UEP_ASSERT(a_done_high, !(valid_s2 && res_s2.tx_done && !res_s2.tx_level), "tx_done on low line")
	// a blocked input word stays in the input register
	`UEP_ASSERT_NEXT(a_s1_hold, valid_s1 && !advance, valid_s1, "input word lost")

endmodule
